// ===== rtl/lapsharp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapsharp_pkg
// Shared constants and types for the 3x3 laplacian sharpening block.
// ----------------------------------------------------------------------------
package lapsharp_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int HEIGHT_CAP     = 4096;
  localparam int MIN_DIM        = 3;

  localparam int PIX_W          = 8;
  localparam int FW_REG_W       = 12;
  localparam int FH_REG_W       = 13;
  localparam int ROW_W          = 12;
  localparam int LAP_W          = 12;

  localparam logic [FW_REG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_REG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;

  // register indexes (byte address / 4)
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // divide by 3 as multiply by reciprocal, exact for magnitudes up to 2040
  localparam logic [9:0] DIV3_RECIP = 10'd683;
  localparam int         DIV3_SHIFT = 11;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

// ===== rtl/lapsharp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapsharp_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
module lapsharp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lapsharp_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapsharp_regs
// APB register file for frame size, with clamped effective dimensions.
// ----------------------------------------------------------------------------
module lapsharp_regs
  import lapsharp_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [APB_ADDR_W-1:0]          paddr,
  input  logic [APB_DATA_W-1:0]          pwdata,
  output logic [APB_DATA_W-1:0]          prdata,
  output logic                           pready,
  output logic [$clog2(MAX_WIDTH)-1:0]   width_m1,
  output logic [ROW_W-1:0]               height_m1,
  output logic                           restart
);

  logic [FW_REG_W-1:0] frame_width;
  logic [FH_REG_W-1:0] frame_height;
  logic                reg_idx;
  logic [31:0]         fw_ext;
  logic [31:0]         fh_ext;
  logic [31:0]         w_eff;
  logic [31:0]         h_eff;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign restart = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (restart) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_REG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
    endcase
  end

  // clamp to the supported frame size
  always_comb begin
    fw_ext = 32'(frame_width);
    fh_ext = 32'(frame_height);
    if (fw_ext < 32'(MIN_DIM)) begin
      w_eff = 32'(MIN_DIM);
    end else if (fw_ext > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    if (fh_ext < 32'(MIN_DIM)) begin
      h_eff = 32'(MIN_DIM);
    end else if (fh_ext > 32'(HEIGHT_CAP)) begin
      h_eff = 32'(HEIGHT_CAP);
    end else begin
      h_eff = fh_ext;
    end
    width_m1  = ($clog2(MAX_WIDTH))'(w_eff - 32'd1);
    height_m1 = ROW_W'(h_eff - 32'd1);
  end

endmodule

// ===== rtl/lapsharp_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapsharp_scan
// Raster position counters and per-pixel output tags.
// ----------------------------------------------------------------------------
module lapsharp_scan
  import lapsharp_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           restart,
  input  logic                           accept,
  input  logic [$clog2(MAX_WIDTH)-1:0]   width_m1,
  input  logic [ROW_W-1:0]               height_m1,
  output logic [$clog2(MAX_WIDTH)-1:0]   col,
  output logic [$clog2(MAX_WIDTH)-1:0]   tag_col,
  output logic [ROW_W-1:0]               tag_row,
  output logic                           tag_emit,
  output logic                           tag_last
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [ROW_W-1:0] row;
  logic [CW-1:0]    col_next;
  logic [ROW_W-1:0] row_next;

  always_comb begin
    col_next = col + CW'(1);
    row_next = row;
    if (col == width_m1) begin
      col_next = '0;
      row_next = (row == height_m1) ? '0 : row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // window centre sits one row up and one column left of the newest pixel
  assign tag_emit = (row >= ROW_W'(2)) && (col >= CW'(2));
  assign tag_row  = row - ROW_W'(1);
  assign tag_col  = col - CW'(1);
  assign tag_last = (row == height_m1) && (col == width_m1);

endmodule

// ===== rtl/lapsharp_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapsharp_window
// Line store read-modify-write, 3x3 window and laplacian sum stage.
// ----------------------------------------------------------------------------
module lapsharp_window
  import lapsharp_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           accept,
  input  logic [PIX_W-1:0]               pixel_in,
  input  logic [$clog2(MAX_WIDTH)-1:0]   col,
  input  logic [$clog2(MAX_WIDTH)-1:0]   tag_col,
  input  logic [ROW_W-1:0]               tag_row,
  input  logic                           tag_emit,
  input  logic                           tag_last,
  output stage_ctl_t                     lap_ctl,
  output logic signed [LAP_W-1:0]        lap,
  output logic [PIX_W-1:0]               lap_centre,
  output logic [ROW_W-1:0]               lap_row,
  output logic [$clog2(MAX_WIDTH)-1:0]   lap_col
);

  localparam int CW = $clog2(MAX_WIDTH);

  // line store word: [15:8] two rows up, [7:0] one row up
  logic [2*PIX_W-1:0] ls_rdata;
  logic [2*PIX_W-1:0] ls_wdata;
  logic               ls_we;

  logic               s1_valid;
  logic [PIX_W-1:0]   s1_px;
  logic [CW-1:0]      s1_addr;
  logic [CW-1:0]      s1_col;
  logic [ROW_W-1:0]   s1_row;
  logic               s1_emit;
  logic               s1_last;

  stage_ctl_t         s2_ctl;
  logic [CW-1:0]      s2_col;
  logic [ROW_W-1:0]   s2_row;

  logic [PIX_W-1:0]   win [9];
  logic [10:0]        ring;
  logic signed [LAP_W-1:0] lap_sum;

  // each column is read w >= 3 pixels after its last write, no overlap
  assign ls_we    = advance && s1_valid;
  assign ls_wdata = {ls_rdata[PIX_W-1:0], s1_px};

  lapsharp_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ls_we),
    .waddr (s1_addr),
    .wdata (ls_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (ls_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_ctl   <= '0;
      lap_ctl  <= '0;
    end else if (advance) begin
      s1_valid <= accept;
      s2_ctl   <= '{valid: s1_valid && s1_emit, last: s1_last};
      lap_ctl  <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_px      <= pixel_in;
      s1_addr    <= col;
      s1_col     <= tag_col;
      s1_row     <= tag_row;
      s1_emit    <= tag_emit;
      s1_last    <= tag_last;
      s2_col     <= s1_col;
      s2_row     <= s1_row;
      lap        <= lap_sum;
      lap_centre <= win[4];
      lap_row    <= s2_row;
      lap_col    <= s2_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (advance && s1_valid) begin
      for (int k = 0; k < 3; k++) begin
        win[3*k]   <= win[3*k+1];
        win[3*k+1] <= win[3*k+2];
      end
      win[2] <= ls_rdata[2*PIX_W-1:PIX_W];
      win[5] <= ls_rdata[PIX_W-1:0];
      win[8] <= s1_px;
    end
  end

  always_comb begin
    ring = 11'(win[0]) + 11'(win[1]) + 11'(win[2]) + 11'(win[3])
         + 11'(win[5]) + 11'(win[6]) + 11'(win[7]) + 11'(win[8]);
    lap_sum = $signed({1'b0, win[4], 3'b000}) - $signed({1'b0, ring});
  end

endmodule

// ===== rtl/lapsharp_post.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapsharp_post
// Divide by three, add centre, clamp; output register with skid stage.
// ----------------------------------------------------------------------------
module lapsharp_post
  import lapsharp_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  stage_ctl_t                     lap_ctl,
  input  logic signed [LAP_W-1:0]        lap,
  input  logic [PIX_W-1:0]               lap_centre,
  input  logic [ROW_W-1:0]               lap_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]   lap_col,
  output logic                           advance,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [PIX_W-1:0]               pixel_out,
  output logic [ROW_W-1:0]               out_row,
  output logic [$clog2(MAX_WIDTH)-1:0]   out_col,
  output logic                           frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [10:0]        mag;
  logic [20:0]        prod;
  logic [9:0]         q_mag;
  logic signed [11:0] v;
  logic [PIX_W-1:0]   res;
  logic               push;

  logic               skid_valid;
  logic [PIX_W-1:0]   skid_pix;
  logic [ROW_W-1:0]   skid_row;
  logic [CW-1:0]      skid_col;
  logic               skid_last;

  // truncating divide: work on the magnitude, restore the sign
  always_comb begin
    mag   = lap[LAP_W-1] ? 11'(-lap) : 11'(lap);
    prod  = 21'(mag) * 21'(DIV3_RECIP);
    q_mag = prod[DIV3_SHIFT +: 10];
    if (lap[LAP_W-1]) begin
      v = $signed({4'b0000, lap_centre}) - $signed({2'b00, q_mag});
    end else begin
      v = $signed({4'b0000, lap_centre}) + $signed({2'b00, q_mag});
    end
    if (v < 0) begin
      res = '0;
    end else if (v > 12'sd255) begin
      res = 8'hff;
    end else begin
      res = v[PIX_W-1:0];
    end
  end

  assign advance = !skid_valid;
  assign push    = advance && lap_ctl.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        pixel_out  <= skid_pix;
        out_row    <= skid_row;
        out_col    <= skid_col;
        frame_last <= skid_last;
      end else begin
        pixel_out  <= res;
        out_row    <= lap_row;
        out_col    <= lap_col;
        frame_last <= lap_ctl.last;
      end
    end else if (push) begin
      skid_pix  <= res;
      skid_row  <= lap_row;
      skid_col  <= lap_col;
      skid_last <= lap_ctl.last;
    end
  end

endmodule

// ===== rtl/laplacian_sharpen_3x3_top.sv =====
`timescale 1ns / 1ps
// path: an accepted pixel passes the s1 registers, the window and s2 stage,
// the lap register and the output register; throughput: one pixel per cycle
// while in_ready is high, set by the single line store read and write-back.
// in_ready drops only while the output register and skid stage are both full.
// reset (synchronous) clears counters, window and pipeline valids; the line
// store contents are left as they are, no clearing pass.
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_top
// Streaming 3x3 laplacian sharpening of a raster-order grayscale frame.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_top
  import lapsharp_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [APB_ADDR_W-1:0]          paddr,
  input  logic [APB_DATA_W-1:0]          pwdata,
  output logic [APB_DATA_W-1:0]          prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [PIX_W-1:0]               pixel_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [PIX_W-1:0]               pixel_out,
  output logic [ROW_W-1:0]               out_row,
  output logic [$clog2(MAX_WIDTH)-1:0]   out_col,
  output logic                           frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                    restart;
  logic [CW-1:0]           width_m1;
  logic [ROW_W-1:0]        height_m1;
  logic                    advance;
  logic                    accept;
  logic [CW-1:0]           col;
  logic [CW-1:0]           tag_col;
  logic [ROW_W-1:0]        tag_row;
  logic                    tag_emit;
  logic                    tag_last;
  stage_ctl_t              lap_ctl;
  logic signed [LAP_W-1:0] lap;
  logic [PIX_W-1:0]        lap_centre;
  logic [ROW_W-1:0]        lap_row;
  logic [CW-1:0]           lap_col;

  assign in_ready = advance;
  assign accept   = in_valid && advance;

  lapsharp_regs #(.MAX_WIDTH(MAX_WIDTH)) u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .width_m1  (width_m1),
    .height_m1 (height_m1),
    .restart   (restart)
  );

  lapsharp_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .accept    (accept),
    .width_m1  (width_m1),
    .height_m1 (height_m1),
    .col       (col),
    .tag_col   (tag_col),
    .tag_row   (tag_row),
    .tag_emit  (tag_emit),
    .tag_last  (tag_last)
  );

  lapsharp_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .accept     (accept),
    .pixel_in   (pixel_in),
    .col        (col),
    .tag_col    (tag_col),
    .tag_row    (tag_row),
    .tag_emit   (tag_emit),
    .tag_last   (tag_last),
    .lap_ctl    (lap_ctl),
    .lap        (lap),
    .lap_centre (lap_centre),
    .lap_row    (lap_row),
    .lap_col    (lap_col)
  );

  lapsharp_post #(.MAX_WIDTH(MAX_WIDTH)) u_post (
    .clk        (clk),
    .rst        (rst),
    .lap_ctl    (lap_ctl),
    .lap        (lap),
    .lap_centre (lap_centre),
    .lap_row    (lap_row),
    .lap_col    (lap_col),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last)
  );

endmodule

// ===== rtl/lapsharp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapsharp_checker
// Port-level checks for the sharpening block, bound to the top level.
// ----------------------------------------------------------------------------
module lapsharp_checker
  import lapsharp_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [PIX_W-1:0]             pixel_out,
  input logic [ROW_W-1:0]             out_row,
  input logic [$clog2(MAX_WIDTH)-1:0] out_col,
  input logic                         frame_last
);

  // nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // input is only back-pressured while a result is held at the output
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // results are interior pixels only
  a_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_row != '0) && (out_col != '0))
    else $error("result on a border pixel");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(out_row)
      && $stable(out_col) && $stable(frame_last))
    else $error("result changed while stalled");

endmodule

bind laplacian_sharpen_3x3_top lapsharp_checker #(.MAX_WIDTH(MAX_WIDTH)) u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .pixel_out  (pixel_out),
  .out_row    (out_row),
  .out_col    (out_col),
  .frame_last (frame_last)
);

// ===== verif/laplacian_sharpen_3x3_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_top_tb
// Self-checking bench for the 3x3 sharpening stream. Raster frames of many
// sizes go in through the pixel port under bursty input and a stalling output.
// A predictor works out every interior result, and each result is checked
// field by field in order. The frame size registers are written and read back
// over APB between frames.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_top_tb;
  import lapsharp_pkg::*;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 10;
  localparam int RANDOM_ITEMS     = 250;
  localparam int WIDE_ITEMS       = 128;
  localparam int TALL_ITEMS       = 96;
  localparam int SETTLE_CYCLES    = 10;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int MAX_REPORTS      = 10;
  localparam int COL_W            = $clog2(DEF_MAX_WIDTH);

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } sharp_px_t;

  typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_FLAT} pix_style_t;
  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_BUSY} rx_mode_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      pixel_out;
  logic [ROW_W-1:0]      out_row;
  logic [COL_W-1:0]      out_col;
  logic                  frame_last;

  // predictor state
  logic [PIX_W-1:0]    row_above  [DEF_MAX_WIDTH];
  logic [PIX_W-1:0]    row_two_up [DEF_MAX_WIDTH];
  logic [PIX_W-1:0]    sharp_win  [9];
  int                  next_col;
  int                  next_row;
  logic [FW_REG_W-1:0] width_reg;
  logic [FH_REG_W-1:0] height_reg;

  logic [PIX_W-1:0] source_pixels [$];
  sharp_px_t        pending_sharp [$];
  int               fail_count  = 0;
  int               cycle_count = 0;
  bit               hold_request = 1'b0;

  int       burst_left = 0;
  int       gap_left   = 0;
  rx_mode_t rx_mode    = RX_ALWAYS;
  int       mode_left  = 0;
  int       hold_left  = 0;
  bit       hold_done  = 1'b0;

  laplacian_sharpen_3x3_top uut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic void note_fail(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic int clamp_dim(input int v, input int hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // shift the window, update the line stores, queue a result for interior pixels
  function automatic void predict_sharpen(input logic [PIX_W-1:0] px);
    int w, h, c, r, centre, ring, v;
    sharp_px_t res;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, HEIGHT_CAP);
    if (next_col >= w) next_col = 0;
    if (next_row >= h) next_row = 0;
    c = next_col;
    r = next_row;
    for (int k = 0; k < 3; k++) begin
      sharp_win[3*k]   = sharp_win[3*k+1];
      sharp_win[3*k+1] = sharp_win[3*k+2];
    end
    sharp_win[2]  = row_two_up[c];
    sharp_win[5]  = row_above[c];
    sharp_win[8]  = px;
    row_two_up[c] = row_above[c];
    row_above[c]  = px;
    if (r >= 2 && c >= 2) begin
      centre = sharp_win[4];
      ring = 0;
      for (int k = 0; k < 9; k++) begin
        if (k != 4) ring += sharp_win[k];
      end
      // int division truncates toward zero
      v = (8 * centre - ring) / 3 + centre;
      if (v > 255) v = 255;
      if (v < 0) v = 0;
      res.pix  = v[PIX_W-1:0];
      res.row  = ROW_W'(r - 1);
      res.col  = COL_W'(c - 1);
      res.last = (r == h - 1) && (c == w - 1);
      pending_sharp.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
  endfunction

  function automatic pix_style_t pick_style();
    case ($urandom_range(0, 3))
      0: return PIX_EXTREME;
      1: return PIX_FLAT;
      default: return PIX_RANDOM;
    endcase
  endfunction

  function automatic void queue_pixels(input int count, input pix_style_t style);
    int base, v;
    base = $urandom_range(0, 255);
    for (int i = 0; i < count; i++) begin
      case (style)
        PIX_EXTREME: source_pixels.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
        PIX_FLAT: begin
          v = base + int'($urandom_range(0, 6)) - 3;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          source_pixels.push_back(v[PIX_W-1:0]);
        end
        default: source_pixels.push_back(PIX_W'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  // setup cycle, access cycle until pready, then psel and penable drop to idle
  task automatic apb_access(input logic [APB_ADDR_W-1:0] addr, input bit is_write,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic reg_idx, input logic [APB_DATA_W-1:0] want);
    logic [APB_DATA_W-1:0] rdata;
    apb_access({reg_idx, 2'b00}, 1'b0, '0, rdata);
    if (rdata !== want)
      note_fail($sformatf("register %0d readback: expected %0d, got %0d",
                          reg_idx, want, rdata));
  endtask

  // junk in the bits above the register is dropped by the block
  task automatic write_frame_reg(input logic reg_idx, input int value);
    logic [APB_DATA_W-1:0] wdata, rdata, want;
    wdata = $urandom_range(0, 1) ? $urandom() : '0;
    want  = '0;
    if (reg_idx == REG_FRAME_WIDTH) begin
      wdata[FW_REG_W-1:0] = value[FW_REG_W-1:0];
      want[FW_REG_W-1:0]  = value[FW_REG_W-1:0];
    end else begin
      wdata[FH_REG_W-1:0] = value[FH_REG_W-1:0];
      want[FH_REG_W-1:0]  = value[FH_REG_W-1:0];
    end
    apb_access({reg_idx, 2'b00}, 1'b1, wdata, rdata);
    if (reg_idx == REG_FRAME_WIDTH) width_reg = wdata[FW_REG_W-1:0];
    else height_reg = wdata[FH_REG_W-1:0];
    // any write restarts the frame
    next_col = 0;
    next_row = 0;
    check_reg(reg_idx, want);
  endtask

  task automatic wait_idle();
    while (source_pixels.size() != 0 || in_valid || pending_sharp.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // pixel sender: random bursts and gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_sharpen(pixel_in);
      if (in_valid && !in_ready) begin
        // hold the request until taken
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (source_pixels.size() != 0) begin
        in_valid <= 1'b1;
        pixel_in <= source_pixels.pop_front();
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
          gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: stall pattern is redrawn at random whenever its mode runs out
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0: rx_mode = RX_ALWAYS;
          1: rx_mode = RX_COIN;
          2: rx_mode = RX_SPARSE;
          default: rx_mode = RX_BUSY;
        endcase
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (hold_request && !hold_done) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) out_ready <= 1'b0;
      else begin
        case (rx_mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= (mode_left % 4 == 0);
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    sharp_px_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_sharp.size() == 0) begin
        note_fail($sformatf("unexpected result: pix %0d row %0d col %0d last %0b",
                            pixel_out, out_row, out_col, frame_last));
      end else begin
        want = pending_sharp.pop_front();
        if (pixel_out !== want.pix || out_row !== want.row || out_col !== want.col ||
            frame_last !== want.last)
          note_fail($sformatf({"mismatch: expected pix %0d row %0d col %0d last %0b,",
                               " got pix %0d row %0d col %0d last %0b"},
                              want.pix, want.row, want.col, want.last,
                              pixel_out, out_row, out_col, frame_last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [PIX_W-1:0] trunc_frame [9];
    logic [PIX_W-1:0] clamp_frame [12];
    int  w_raw, h_raw, count, random_done;
    bit  first_pass;

    // centre 10 with ring sum 81: -1/3 must give 0, not -1
    trunc_frame = '{11, 10, 10, 10, 10, 10, 10, 10, 10};
    // dark centre in bright ring, then bright centre over a dark row
    clamp_frame = '{255, 255, 255, 255, 0, 255,
                    255, 255, 255, 0, 0, 0};

    for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
      row_above[i]  = '0;
      row_two_up[i] = '0;
    end
    foreach (sharp_win[i]) sharp_win[i] = '0;
    next_col   = 0;
    next_row   = 0;
    width_reg  = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_reg(REG_FRAME_WIDTH, APB_DATA_W'(FRAME_WIDTH_RST));
    check_reg(REG_FRAME_HEIGHT, APB_DATA_W'(FRAME_HEIGHT_RST));

    // sizes below the minimum clamp to 3x3
    write_frame_reg(REG_FRAME_WIDTH, 1);
    write_frame_reg(REG_FRAME_HEIGHT, 0);
    foreach (trunc_frame[i]) source_pixels.push_back(trunc_frame[i]);
    wait_idle();
    write_frame_reg(REG_FRAME_HEIGHT, 4);
    foreach (clamp_frame[i]) source_pixels.push_back(clamp_frame[i]);
    wait_idle();

    // small random frames, some cut off by a restart mid-frame
    random_done = 0;
    first_pass  = 1'b1;
    while (random_done < RANDOM_ITEMS) begin
      w_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
      h_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      case ($urandom_range(0, 2))
        0: write_frame_reg(REG_FRAME_WIDTH, w_raw);
        1: write_frame_reg(REG_FRAME_HEIGHT, h_raw);
        default: begin
          write_frame_reg(REG_FRAME_HEIGHT, h_raw);
          write_frame_reg(REG_FRAME_WIDTH, w_raw);
        end
      endcase
      count = clamp_dim(width_reg, DEF_MAX_WIDTH) * clamp_dim(height_reg, HEIGHT_CAP) *
              $urandom_range(1, 2);
      if (first_pass || $urandom_range(0, 2) == 0) count = $urandom_range(1, count - 1);
      if (count > RANDOM_ITEMS - random_done) count = RANDOM_ITEMS - random_done;
      first_pass = 1'b0;
      queue_pixels(count, pick_style());
      random_done += count;
      wait_idle();
    end

    // over-range width clamps to the line store size, part of the first row only
    write_frame_reg(REG_FRAME_HEIGHT, 3);
    write_frame_reg(REG_FRAME_WIDTH, 4095);
    queue_pixels(WIDE_ITEMS, PIX_RANDOM);
    wait_idle();

    // tall frame, narrow; the receiver backs off for a long stretch here
    write_frame_reg(REG_FRAME_WIDTH, 3);
    write_frame_reg(REG_FRAME_HEIGHT, 8191);
    hold_request = 1'b1;
    queue_pixels(TALL_ITEMS, pick_style());
    wait_idle();

    if (fail_count == 0 && pending_sharp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
